>>> sv/mlp_pkg.sv
// shared constants, types and layer tables of the int8 mlp classifier
// depends on nothing; used by the interfaces, the mac unit and the top level
package mlp_pkg;

    // network shape
    localparam int INPUTS     = 32;
    localparam int HIDDEN_ONE = 24;
    localparam int HIDDEN_TWO = 16;
    localparam int OUTPUTS    = 6;

    // weight store layout, row-major per neuron
    localparam int W2_BASE = INPUTS * HIDDEN_ONE;
    localparam int W3_BASE = W2_BASE + HIDDEN_ONE * HIDDEN_TWO;
    localparam int W_DEPTH = W3_BASE + HIDDEN_TWO * OUTPUTS;

    // bias store layout
    localparam int B2_BASE = HIDDEN_ONE;
    localparam int B3_BASE = B2_BASE + HIDDEN_TWO;
    localparam int B_DEPTH = B3_BASE + OUTPUTS;

    // activation store: features, then hidden one, then hidden two
    localparam int ACT_H1_BASE = INPUTS;
    localparam int ACT_H2_BASE = ACT_H1_BASE + HIDDEN_ONE;
    localparam int ACT_DEPTH   = ACT_H2_BASE + HIDDEN_TWO;

    localparam int MAX_FANIN  = (INPUTS > HIDDEN_ONE) ?
                                ((INPUTS > HIDDEN_TWO) ? INPUTS : HIDDEN_TWO) :
                                ((HIDDEN_ONE > HIDDEN_TWO) ? HIDDEN_ONE : HIDDEN_TWO);
    localparam int MAX_FANOUT = (HIDDEN_ONE > HIDDEN_TWO) ?
                                ((HIDDEN_ONE > OUTPUTS) ? HIDDEN_ONE : OUTPUTS) :
                                ((HIDDEN_TWO > OUTPUTS) ? HIDDEN_TWO : OUTPUTS);

    localparam int W_AW     = $clog2(W_DEPTH);
    localparam int B_AW     = $clog2(B_DEPTH);
    localparam int ACT_AW   = $clog2(ACT_DEPTH);
    localparam int STEP_W   = $clog2(MAX_FANIN);
    localparam int NEURON_W = $clog2(MAX_FANOUT);
    localparam int LOGIT_AW = $clog2(OUTPUTS);

    // field widths
    localparam int REQ_W   = 2;
    localparam int ADDR_W  = 11;
    localparam int DATA_W  = 32;
    localparam int SHIFT_W = 5;
    localparam int CLASS_W = 3;
    localparam int QUANT_W = 8;
    localparam int ACT_W   = 8;
    localparam int ACC_W   = 32;

    localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(8);
    localparam int QMAX = 127;

    // request codes
    localparam logic [REQ_W-1:0] REQ_WEIGHT  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_BIAS    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FEATURE = 2'd2;

    typedef enum logic [1:0] {
        LAYER_ONE,
        LAYER_TWO,
        LAYER_OUT
    } t_layer;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_mac_ctl;

    function automatic logic [STEP_W-1:0] layer_last_step(input t_layer l);
        unique case (l)
            LAYER_ONE: layer_last_step = STEP_W'(INPUTS - 1);
            LAYER_TWO: layer_last_step = STEP_W'(HIDDEN_ONE - 1);
            LAYER_OUT: layer_last_step = STEP_W'(HIDDEN_TWO - 1);
            default:   layer_last_step = '0;
        endcase
    endfunction

    function automatic logic [NEURON_W-1:0] layer_last_neuron(input t_layer l);
        unique case (l)
            LAYER_ONE: layer_last_neuron = NEURON_W'(HIDDEN_ONE - 1);
            LAYER_TWO: layer_last_neuron = NEURON_W'(HIDDEN_TWO - 1);
            LAYER_OUT: layer_last_neuron = NEURON_W'(OUTPUTS - 1);
            default:   layer_last_neuron = '0;
        endcase
    endfunction

    function automatic logic [W_AW-1:0] layer_row_len(input t_layer l);
        unique case (l)
            LAYER_ONE: layer_row_len = W_AW'(INPUTS);
            LAYER_TWO: layer_row_len = W_AW'(HIDDEN_ONE);
            LAYER_OUT: layer_row_len = W_AW'(HIDDEN_TWO);
            default:   layer_row_len = '0;
        endcase
    endfunction

    function automatic logic [ACT_AW-1:0] layer_in_base(input t_layer l);
        unique case (l)
            LAYER_ONE: layer_in_base = '0;
            LAYER_TWO: layer_in_base = ACT_AW'(ACT_H1_BASE);
            LAYER_OUT: layer_in_base = ACT_AW'(ACT_H2_BASE);
            default:   layer_in_base = '0;
        endcase
    endfunction

    function automatic logic [ACT_AW-1:0] layer_out_base(input t_layer l);
        unique case (l)
            LAYER_ONE: layer_out_base = ACT_AW'(ACT_H1_BASE);
            LAYER_TWO: layer_out_base = ACT_AW'(ACT_H2_BASE);
            default:   layer_out_base = '0;
        endcase
    endfunction

endpackage

>>> sv/mlp_if.sv
// valid/ready channel interfaces: request, result and configuration
// depends on mlp_pkg for field widths
interface mlp_req_if;
    logic                                valid;
    logic                                ready;
    logic        [mlp_pkg::REQ_W-1:0]    req_type;
    logic        [mlp_pkg::ADDR_W-1:0]   address;
    logic signed [mlp_pkg::DATA_W-1:0]   data_value;

    modport source(output valid, req_type, address, data_value, input ready);
    modport sink(input valid, req_type, address, data_value, output ready);
endinterface

interface mlp_res_if;
    logic                                valid;
    logic                                ready;
    logic        [mlp_pkg::CLASS_W-1:0]  class_index;
    logic signed [mlp_pkg::ACC_W-1:0]    logit;
    logic signed [mlp_pkg::QUANT_W-1:0]  logit_quantized;
    logic        [mlp_pkg::CLASS_W-1:0]  predicted_class;
    logic                                last;

    modport source(output valid, class_index, logit, logit_quantized, predicted_class,
                   last, input ready);
    modport sink(input valid, class_index, logit, logit_quantized, predicted_class,
                 last, output ready);
endinterface

interface mlp_cfg_if;
    logic                                valid;
    logic                                ready;
    logic        [mlp_pkg::SHIFT_W-1:0]  data;

    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface

>>> sv/mlp_mac.sv
// shared multiply-accumulate unit: registered int8 product, then 32-bit wrapping sum
// depends on mlp_pkg for t_mac_ctl and widths
module mlp_mac (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  mlp_pkg::t_mac_ctl                  i_ctl,
    input  logic signed [mlp_pkg::ACT_W-1:0]   i_act,
    input  logic signed [mlp_pkg::ACT_W-1:0]   i_weight,
    input  logic signed [mlp_pkg::ACC_W-1:0]   i_bias,
    output logic signed [mlp_pkg::ACC_W-1:0]   o_acc,
    output logic                               o_done
);
    import mlp_pkg::*;

    localparam int PROD_W = 2 * ACT_W;

    t_mac_ctl                  r_ctl;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_bias;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ACC_W-1:0]   n_acc;
    logic                      r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl  <= '0;
            r_done <= 1'b0;
        end else begin
            r_ctl  <= i_ctl;
            r_done <= r_ctl.valid && r_ctl.last;
        end
    end

    // bias rides along with the first product of a neuron
    always_comb begin
        n_acc = (r_ctl.first ? r_bias : r_acc) + ACC_W'(r_prod);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_act * i_weight;
        if (i_ctl.valid && i_ctl.first) begin
            r_bias <= i_bias;
        end
        if (r_ctl.valid) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc  = r_acc;
    assign o_done = r_done;

endmodule

>>> sv/int8_mlp_classifier_top.sv
// int8 mlp classifier (32-24-16-6) top level: stores, sequencer, result register
// depends on mlp_pkg, the interfaces in mlp_if.sv and mlp_mac
//
// usage
//   i_req carries weight writes, bias writes and features (valid/ready transfer).
//   weights and features keep only their low byte; biases keep all 32 bits.
//   a write to an address beyond its store, or an unused request code, is dropped.
//   the feature at index 31 starts an inference; i_req.ready stays low until
//   the six results have been handed to the result register.
//   i_cfg writes requant_shift at any transfer (ready is always high); change it
//   only while no inference runs.
// sequencing
//   writes and non-final features are taken back to back while idle.
//   an inference runs every neuron in turn, issuing one mac step per fan-in
//   input, on the one shared mac and its three-stage pipe (memory read,
//   product, accumulate) that drains before the next neuron, since a layer
//   reads what the previous one just wrote. then the results load into the
//   result register one per class in class order; last marks class five.
// reset: control state clears and requant_shift returns to 8; stores keep
//   whatever they hold and must be written before use.
// stalls: results sit in an output register; a stalled receiver holds the
//   sequencer in its emit phase. the last result may wait while new requests are taken.
module int8_mlp_classifier_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mlp_req_if.sink      i_req,
    mlp_cfg_if.sink      i_cfg,
    mlp_res_if.source    o_res
);
    import mlp_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_EMIT  = 4'b1000
    } t_state;

    // sequencer state
    t_state                 r_state,  n_state;
    t_layer                 r_layer,  n_layer;
    logic [NEURON_W-1:0]    r_neuron, n_neuron;
    logic [STEP_W-1:0]      r_step,   n_step;
    logic [W_AW-1:0]        r_wrow,   n_wrow;
    logic [B_AW-1:0]        r_bidx,   n_bidx;
    logic [LOGIT_AW-1:0]    r_emit,   n_emit;
    logic [SHIFT_W-1:0]     r_shift;

    // stores
    logic        [ACT_W-1:0]  mem_weight [W_DEPTH];
    logic        [ACC_W-1:0]  mem_bias   [B_DEPTH];
    logic        [ACT_W-1:0]  mem_act    [ACT_DEPTH];
    logic signed [ACC_W-1:0]  r_logit    [OUTPUTS];

    logic signed [ACT_W-1:0]  r_weight_q;
    logic signed [ACT_W-1:0]  r_act_q;
    logic signed [ACC_W-1:0]  r_bias_q;

    // argmax tracking
    logic signed [ACC_W-1:0]  r_best;
    logic [LOGIT_AW-1:0]      r_lead_class;

    // mac interface
    t_mac_ctl                 r_s1;
    logic signed [ACC_W-1:0]  w_acc;
    logic                     w_done;

    // result register
    logic                     r_res_valid;
    logic [CLASS_W-1:0]       r_res_class;
    logic signed [ACC_W-1:0]  r_res_logit;
    logic signed [QUANT_W-1:0] r_res_quant;
    logic [CLASS_W-1:0]       r_res_pred;
    logic                     r_res_last;

    logic                     w_in_xfer;
    logic                     w_wr_weight;
    logic                     w_wr_bias;
    logic                     w_wr_feat;
    logic                     w_start;
    logic                     w_act_we;
    logic [ACT_AW-1:0]        w_act_waddr;
    logic [ACT_W-1:0]         w_act_wdata;
    logic [W_AW-1:0]          w_weight_raddr;
    logic [ACT_AW-1:0]        w_act_raddr;
    logic                     w_last_step;
    logic                     w_res_load;
    logic signed [ACC_W-1:0]  w_emit_logit;
    logic signed [ACC_W-1:0]  w_emit_shifted;

    // shift, clamp to int8 and relu in one go: negatives go to zero
    function automatic logic [ACT_W-1:0] requant(input logic signed [ACC_W-1:0] acc,
                                                 input logic [SHIFT_W-1:0] sh);
        logic signed [ACC_W-1:0] v;
        v = acc >>> sh;
        if (v[ACC_W-1]) begin
            requant = '0;
        end else if (v > ACC_W'(QMAX)) begin
            requant = ACT_W'(QMAX);
        end else begin
            requant = v[ACT_W-1:0];
        end
    endfunction

    // request decode
    assign i_req.ready = (r_state == ST_IDLE);
    assign w_in_xfer   = i_req.valid && i_req.ready;
    assign w_wr_weight = w_in_xfer && (i_req.req_type == REQ_WEIGHT) &&
                         (i_req.address < ADDR_W'(W_DEPTH));
    assign w_wr_bias   = w_in_xfer && (i_req.req_type == REQ_BIAS) &&
                         (i_req.address < ADDR_W'(B_DEPTH));
    assign w_wr_feat   = w_in_xfer && (i_req.req_type == REQ_FEATURE) &&
                         (i_req.address < ADDR_W'(INPUTS));
    assign w_start     = w_wr_feat && (i_req.address == ADDR_W'(INPUTS - 1));

    // configuration register
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= SHIFT_RESET;
        end else if (i_cfg.valid) begin
            r_shift <= i_cfg.data;
        end
    end

    // read addresses for the current mac step
    assign w_weight_raddr = r_wrow + W_AW'(r_step);
    assign w_act_raddr    = layer_in_base(r_layer) + ACT_AW'(r_step);
    assign w_last_step    = (r_step == layer_last_step(r_layer));

    // activation store takes features while idle and hidden outputs while draining
    assign w_act_we    = w_wr_feat || (w_done && (r_layer != LAYER_OUT));
    assign w_act_waddr = w_wr_feat ? ACT_AW'(i_req.address)
                                   : layer_out_base(r_layer) + ACT_AW'(r_neuron);
    assign w_act_wdata = w_wr_feat ? i_req.data_value[ACT_W-1:0] : requant(w_acc, r_shift);

    always_ff @(posedge i_clk) begin
        if (w_wr_weight) begin
            mem_weight[i_req.address] <= i_req.data_value[ACT_W-1:0];
        end
        r_weight_q <= mem_weight[w_weight_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_bias) begin
            mem_bias[B_AW'(i_req.address)] <= i_req.data_value;
        end
        r_bias_q <= mem_bias[r_bidx];
    end

    always_ff @(posedge i_clk) begin
        if (w_act_we) begin
            mem_act[w_act_waddr] <= w_act_wdata;
        end
        r_act_q <= mem_act[w_act_raddr];
    end

    // control travels alongside the registered read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else begin
            r_s1.valid <= (r_state == ST_ISSUE);
            r_s1.first <= (r_step == '0);
            r_s1.last  <= w_last_step;
        end
    end

    mlp_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (r_s1),
        .i_act    (r_act_q),
        .i_weight (r_weight_q),
        .i_bias   (r_bias_q),
        .o_acc    (w_acc),
        .o_done   (w_done)
    );

    // output layer: keep logits and track the running maximum, first wins ties
    always_ff @(posedge i_clk) begin
        if (w_done && (r_layer == LAYER_OUT)) begin
            r_logit[r_neuron[LOGIT_AW-1:0]] <= w_acc;
            if ((r_neuron == '0) || (w_acc > r_best)) begin
                r_best       <= w_acc;
                r_lead_class <= r_neuron[LOGIT_AW-1:0];
            end
        end
    end

    // a result loads when the register is empty or its transfer completes now
    assign w_res_load     = (r_state == ST_EMIT) && (!r_res_valid || o_res.ready);
    assign w_emit_logit   = r_logit[r_emit];
    assign w_emit_shifted = w_emit_logit >>> r_shift;

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_layer  = r_layer;
        n_neuron = r_neuron;
        n_step   = r_step;
        n_wrow   = r_wrow;
        n_bidx   = r_bidx;
        n_emit   = r_emit;
        unique case (r_state)
            ST_IDLE: begin
                if (w_start) begin
                    n_state  = ST_ISSUE;
                    n_layer  = LAYER_ONE;
                    n_neuron = '0;
                    n_step   = '0;
                    n_wrow   = '0;
                    n_bidx   = '0;
                end
            end
            ST_ISSUE: begin
                if (w_last_step) begin
                    n_state = ST_DRAIN;
                    n_step  = '0;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_DRAIN: begin
                // wait for the neuron to leave the mac before the next one reads
                if (w_done) begin
                    n_state = ST_ISSUE;
                    n_wrow  = r_wrow + layer_row_len(r_layer);
                    n_bidx  = r_bidx + 1'b1;
                    if (r_neuron == layer_last_neuron(r_layer)) begin
                        n_neuron = '0;
                        unique case (r_layer)
                            LAYER_ONE: n_layer = LAYER_TWO;
                            LAYER_TWO: n_layer = LAYER_OUT;
                            default: begin
                                n_state = ST_EMIT;
                                n_emit  = '0;
                            end
                        endcase
                    end else begin
                        n_neuron = r_neuron + 1'b1;
                    end
                end
            end
            ST_EMIT: begin
                if (w_res_load) begin
                    if (r_emit == LOGIT_AW'(OUTPUTS - 1)) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_emit = r_emit + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_layer  <= LAYER_ONE;
            r_neuron <= '0;
            r_step   <= '0;
            r_wrow   <= '0;
            r_bidx   <= '0;
            r_emit   <= '0;
        end else begin
            r_state  <= n_state;
            r_layer  <= n_layer;
            r_neuron <= n_neuron;
            r_step   <= n_step;
            r_wrow   <= n_wrow;
            r_bidx   <= n_bidx;
            r_emit   <= n_emit;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (w_res_load) begin
            r_res_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_load) begin
            r_res_class <= CLASS_W'(r_emit);
            r_res_logit <= w_emit_logit;
            r_res_quant <= w_emit_shifted[QUANT_W-1:0];
            r_res_pred  <= CLASS_W'(r_lead_class);
            r_res_last  <= (r_emit == LOGIT_AW'(OUTPUTS - 1));
        end
    end

    assign o_res.valid           = r_res_valid;
    assign o_res.class_index     = r_res_class;
    assign o_res.logit           = r_res_logit;
    assign o_res.logit_quantized = r_res_quant;
    assign o_res.predicted_class = r_res_pred;
    assign o_res.last            = r_res_last;

    // checks

    // the mac only finishes a neuron while the sequencer waits for it
    a_done_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == ST_DRAIN))
        else $error("mac finished outside of drain");

    // no mac traffic while requests are being taken
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!r_s1.valid && !w_done))
        else $error("mac busy while idle");

    // the final feature starts the layer sweep at once
    a_start_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> ((r_state == ST_ISSUE) && (r_layer == LAYER_ONE) && (r_step == '0)))
        else $error("inference did not start");

    // a shown result names a real class and flags last only on the final class
    a_res_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |-> ((r_res_pred < CLASS_W'(OUTPUTS)) &&
                         (r_res_last == (r_res_class == CLASS_W'(OUTPUTS - 1)))))
        else $error("bad result class");

endmodule

>>> dv/tb_int8_mlp_classifier_top.sv
// testbench of int8_mlp_classifier_top: weight, bias and feature traffic with a checked stream
// of class results; depends on mlp_pkg, the channel interfaces in mlp_if.sv and the top level
`timescale 1ns / 1ps
module tb_int8_mlp_classifier_top;
    import mlp_pkg::*;

    // request code the block leaves unused, dropped without a result
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int QMIN          = -128;
    localparam int ADDR_MAX      = 2 ** ADDR_W - 1;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 16;     // writes land in the store at their transfer, so this is plenty
    localparam int HOLD_CYCLES   = 3000;   // longer than one inference
    localparam int MAX_REPORTS   = 10;
    // worst case is every random request a final feature under the longest stalls;
    // this limit is meant to allow several times that
    localparam int LIMIT_NS      = 20_000_000;

    typedef struct packed {
        logic        [CLASS_W-1:0] class_index;
        logic signed [ACC_W-1:0]   logit;
        logic signed [QUANT_W-1:0] logit_quantized;
        logic        [CLASS_W-1:0] predicted_class;
        logic                      last;
    } t_class_report;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mlp_req_if req_ch();
    mlp_cfg_if cfg_ch();
    mlp_res_if res_ch();

    int8_mlp_classifier_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor copy of the network state and the shift register
    logic signed [ACT_W-1:0] m_weights  [W_DEPTH];
    logic signed [ACC_W-1:0] m_biases   [B_DEPTH];
    logic signed [ACT_W-1:0] m_features [INPUTS];
    logic signed [ACT_W-1:0] m_hidden1  [HIDDEN_ONE];
    logic signed [ACT_W-1:0] m_hidden2  [HIDDEN_TWO];
    logic [SHIFT_W-1:0]      m_shift;

    // class results still owed by the block, oldest first
    t_class_report logit_queue[$];

    int total_transfers = 0;   // every accepted request, dropped ones too
    int items_sent      = 0;   // requests that change the stores
    int inference_count = 0;
    int results_seen    = 0;
    int shift_writes    = 0;
    int mismatches      = 0;

    // sender burst control
    bit sender_gaps = 1'b0;
    int burst_left  = 0;

    // receiver stall control
    logic        hold_request = 1'b0;
    int          hold_left    = 0;
    logic [15:0] stall_pattern = 16'hFFFF;
    logic [3:0]  pattern_bit   = '0;
    int          pattern_age   = 0;
    int          stall_style   = 0;

    // ---------------------------------------------------------------- predictor

    // one neuron: bias plus input*weight products, 32-bit wraparound
    function automatic int dot_row(input t_layer layer, input int neuron);
        int acc;
        int n_in;
        int wbase;
        int x;
        case (layer)
            LAYER_ONE: begin
                n_in  = INPUTS;
                wbase = 0;
                acc   = m_biases[neuron];
            end
            LAYER_TWO: begin
                n_in  = HIDDEN_ONE;
                wbase = W2_BASE;
                acc   = m_biases[B2_BASE + neuron];
            end
            default: begin
                n_in  = HIDDEN_TWO;
                wbase = W3_BASE;
                acc   = m_biases[B3_BASE + neuron];
            end
        endcase
        for (int i = 0; i < n_in; i++) begin
            case (layer)
                LAYER_ONE: x = m_features[i];
                LAYER_TWO: x = m_hidden1[i];
                default:   x = m_hidden2[i];
            endcase
            acc += x * int'(m_weights[wbase + neuron * n_in + i]);
        end
        return acc;
    endfunction

    // shift, clamp to int8, then relu
    function automatic logic signed [ACT_W-1:0] requantize(input int acc);
        int r;
        r = acc >>> m_shift;
        if (r > QMAX) r = QMAX;
        if (r < QMIN) r = QMIN;
        if (r < 0) r = 0;
        return ACT_W'(r);
    endfunction

    // full forward pass, queues one report per class in class order
    function automatic void classify_features();
        int sums [OUTPUTS];
        int best;
        int lead_class;
        t_class_report rep;
        for (int j = 0; j < HIDDEN_ONE; j++) m_hidden1[j] = requantize(dot_row(LAYER_ONE, j));
        for (int j = 0; j < HIDDEN_TWO; j++) m_hidden2[j] = requantize(dot_row(LAYER_TWO, j));
        for (int j = 0; j < OUTPUTS; j++) sums[j] = dot_row(LAYER_OUT, j);
        // strict compare keeps the lowest index on a tie
        lead_class = 0;
        best       = sums[0];
        for (int j = 1; j < OUTPUTS; j++) begin
            if (sums[j] > best) begin
                best       = sums[j];
                lead_class = j;
            end
        end
        for (int j = 0; j < OUTPUTS; j++) begin
            rep.class_index     = CLASS_W'(j);
            rep.logit           = sums[j];
            rep.logit_quantized = QUANT_W'(sums[j] >>> m_shift);
            rep.predicted_class = CLASS_W'(lead_class);
            rep.last            = (j == OUTPUTS - 1);
            logit_queue.push_back(rep);
        end
        inference_count++;
    endfunction

    // what one accepted request does to the stores
    function automatic void apply_request(input logic [REQ_W-1:0] kind,
                                          input logic [ADDR_W-1:0] addr,
                                          input logic [DATA_W-1:0] data);
        case (kind)
            REQ_WEIGHT: begin
                if (addr < W_DEPTH) begin
                    m_weights[addr] = data[ACT_W-1:0];
                    items_sent++;
                end
            end
            REQ_BIAS: begin
                if (addr < B_DEPTH) begin
                    m_biases[addr] = data;
                    items_sent++;
                end
            end
            REQ_FEATURE: begin
                if (addr < INPUTS) begin
                    m_features[addr] = data[ACT_W-1:0];
                    items_sent++;
                    // the last feature starts an inference
                    if (addr == INPUTS - 1) classify_features();
                end
            end
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------- random values

    // mostly small weights so sums stay inside the clamp, upper bits always random
    function automatic logic [DATA_W-1:0] weight_word();
        logic [DATA_W-1:0] w;
        w = $urandom;
        if ($urandom_range(0, 3) != 0) w[7:0] = 8'(int'($urandom_range(0, 32)) - 16);
        return w;
    endfunction

    function automatic logic [DATA_W-1:0] feature_word();
        logic [DATA_W-1:0] w;
        w = $urandom;
        if ($urandom_range(0, 1) != 0) w[7:0] = 8'(int'($urandom_range(0, 64)) - 32);
        return w;
    endfunction

    // small biases most of the time, full range now and then to hit wraparound
    function automatic logic [DATA_W-1:0] bias_word();
        if ($urandom_range(0, 7) == 0) return $urandom;
        return DATA_W'(int'($urandom_range(0, 4000)) - 2000);
    endfunction

    // ---------------------------------------------------------------- channel drivers

    // one request transfer; inputs change on the falling edge, ready is looked at on
    // the rising edge, valid stays up until the next call or a drain lowers it
    task automatic send_request(input logic [REQ_W-1:0] kind, input int addr,
                                input logic [DATA_W-1:0] data);
        int gap;
        if (sender_gaps) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 8);
                repeat (gap) begin
                    @(negedge i_clk);
                    req_ch.valid = 1'b0;
                end
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
        end
        @(negedge i_clk);
        req_ch.valid      = 1'b1;
        req_ch.req_type   = kind;
        req_ch.address    = ADDR_W'(addr);
        req_ch.data_value = data;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        total_transfers++;
        apply_request(kind, ADDR_W'(addr), data);
    endtask

    // register write, only called once the block has gone idle
    task automatic write_shift(input logic [SHIFT_W-1:0] value);
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.data  = value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        m_shift = value;
        shift_writes++;
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // stop offering, wait for every owed result, then let the last write settle
    task automatic wait_drained();
        @(negedge i_clk);
        req_ch.valid = 1'b0;
        while (logit_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // every store entry gets a value, the closing feature runs an inference
    task automatic load_network();
        sender_gaps = 1'b0;
        for (int a = 0; a < W_DEPTH; a++) send_request(REQ_WEIGHT, a, weight_word());
        for (int b = 0; b < B_DEPTH; b++) send_request(REQ_BIAS, b, bias_word());
        for (int f = 0; f < INPUTS; f++) send_request(REQ_FEATURE, f, feature_word());
    endtask

    task automatic send_random_request();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)      send_request(REQ_FEATURE, $urandom_range(0, INPUTS - 2), feature_word());
        else if (pick < 57) send_request(REQ_FEATURE, INPUTS - 1, feature_word());
        else if (pick < 72) send_request(REQ_WEIGHT, $urandom_range(0, W_DEPTH - 1), weight_word());
        else if (pick < 82) send_request(REQ_BIAS, $urandom_range(0, B_DEPTH - 1), bias_word());
        // noise: addresses beyond their store, the unused code, any feature address
        else if (pick < 85) send_request(REQ_WEIGHT, $urandom_range(W_DEPTH, ADDR_MAX), $urandom);
        else if (pick < 88) send_request(REQ_BIAS, $urandom_range(B_DEPTH, ADDR_MAX), $urandom);
        else if (pick < 91) send_request(REQ_FEATURE, $urandom_range(INPUTS, ADDR_MAX), $urandom);
        else if (pick < 95) send_request(REQ_UNUSED, $urandom_range(0, ADDR_MAX), $urandom);
        else                send_request(REQ_FEATURE, $urandom_range(0, ADDR_MAX), $urandom);
    endtask

    // ---------------------------------------------------------------- tests

    // full load and one inference at the reset shift of 8
    task automatic test_first_inference();
        load_network();
    endtask

    // field extremes, dropped requests, the tie rule and both shift extremes
    task automatic test_directed_cases();
        wait_drained();
        // zero output layer weights so the logits follow the biases
        sender_gaps = 1'b0;
        for (int a = W3_BASE; a < W_DEPTH; a++) send_request(REQ_WEIGHT, a, '0);
        sender_gaps = 1'b1;
        // only the low byte of a weight is kept
        send_request(REQ_WEIGHT, 0, 32'hFFFF_FF80);
        send_request(REQ_WEIGHT, W_DEPTH - 1, 32'h0000_007F);
        // writes past the end of each store and the unused code are dropped
        send_request(REQ_WEIGHT, W_DEPTH, 32'h0000_0055);
        send_request(REQ_WEIGHT, ADDR_MAX, 32'hFFFF_FFFF);
        send_request(REQ_BIAS, B_DEPTH, 32'h0BAD_0BAD);
        send_request(REQ_BIAS, ADDR_MAX, 32'hFFFF_FFFF);
        send_request(REQ_FEATURE, INPUTS, 32'h0000_0044);
        send_request(REQ_FEATURE, ADDR_MAX, 32'hFFFF_FFFF);
        send_request(REQ_UNUSED, INPUTS - 1, 32'h0000_0011);
        // largest bias on neuron 0, wraps once the products are added
        send_request(REQ_BIAS, 0, 32'h7FFF_FFFF);
        // classes 1 and 3 tie on the largest logit, class 5 holds the smallest bias
        send_request(REQ_BIAS, B3_BASE + 0, -32'sd5);
        send_request(REQ_BIAS, B3_BASE + 1, 32'd100);
        send_request(REQ_BIAS, B3_BASE + 2, 32'd7);
        send_request(REQ_BIAS, B3_BASE + 3, 32'd100);
        send_request(REQ_BIAS, B3_BASE + 4, -32'sd1);
        send_request(REQ_BIAS, B3_BASE + 5, 32'h8000_0000);
        send_request(REQ_FEATURE, 0, 32'hFFFF_FF80);
        send_request(REQ_FEATURE, INPUTS - 1, 32'h0000_007F);
        // no shift at all
        wait_drained();
        write_shift('0);
        send_request(REQ_FEATURE, INPUTS - 1, 32'h1234_5601);
        // largest shift, every hidden neuron collapses to zero
        wait_drained();
        write_shift('1);
        send_request(REQ_FEATURE, INPUTS - 1, 32'hFFFF_FF81);
    endtask

    // fresh output layer weights and all biases, then three phases of mixed traffic
    // at different shifts
    task automatic test_random_traffic();
        logic [SHIFT_W-1:0] shifts [3];
        int start_items;
        int start_inf;
        shifts[0] = SHIFT_W'($urandom_range(1, 30));
        shifts[1] = SHIFT_W'(4);
        shifts[2] = SHIFT_W'(12);
        wait_drained();
        sender_gaps = 1'b0;
        for (int a = W3_BASE; a < W_DEPTH; a++) send_request(REQ_WEIGHT, a, weight_word());
        for (int b = 0; b < B_DEPTH; b++) send_request(REQ_BIAS, b, bias_word());
        for (int p = 0; p < 3; p++) begin
            wait_drained();
            write_shift(shifts[p]);
            start_items = items_sent;
            start_inf   = inference_count;
            // middle phase runs back to back, the others in bursts
            sender_gaps = (p != 1);
            while (items_sent - start_items < 50 || inference_count - start_inf < 3)
                send_random_request();
        end
    endtask

    // receiver holds off while two inferences are offered, the block has to stall
    // its request side until the results drain
    task automatic test_output_backpressure();
        wait_drained();
        sender_gaps  = 1'b0;
        hold_request = 1'b1;
        for (int f = 0; f < INPUTS; f++) send_request(REQ_FEATURE, f, feature_word());
        for (int k = 0; k < 8; k++)
            send_request(REQ_WEIGHT, $urandom_range(0, W_DEPTH - 1), weight_word());
        send_request(REQ_FEATURE, INPUTS - 1, feature_word());
    endtask

    // ---------------------------------------------------------------- result side

    // ready pattern re-chosen when its age counter runs out: sometimes always ready, sometimes
    // a random mask; a requested hold-off is counted down here
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            res_ch.ready = 1'b0;
            hold_left--;
        end else begin
            if (pattern_age == 0) begin
                stall_style   = $urandom_range(0, 3);
                stall_pattern = 16'($urandom) | 16'h0001;
                pattern_age   = 64;
            end
            pattern_age--;
            res_ch.ready = (stall_style == 0) ? 1'b1 : stall_pattern[pattern_bit];
            pattern_bit++;
        end
    end

    // every result transfer is held against the oldest owed report
    always @(posedge i_clk) begin : check_results
        t_class_report want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            results_seen++;
            if (logit_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result with nothing owed, class %0d logit %0d",
                             $time, res_ch.class_index, res_ch.logit);
            end else begin
                want = logit_queue.pop_front();
                if (res_ch.class_index !== want.class_index ||
                    res_ch.logit !== want.logit ||
                    res_ch.logit_quantized !== want.logit_quantized ||
                    res_ch.predicted_class !== want.predicted_class ||
                    res_ch.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"%0t: mismatch, expected class %0d logit %0d quant %0d ",
                                  "pred %0d last %0b, got class %0d logit %0d quant %0d ",
                                  "pred %0d last %0b"}, $time,
                                 want.class_index, want.logit, want.logit_quantized,
                                 want.predicted_class, want.last,
                                 res_ch.class_index, res_ch.logit, res_ch.logit_quantized,
                                 res_ch.predicted_class, res_ch.last);
                end
            end
        end
    end

    // ---------------------------------------------------------------- run

    initial begin
        i_rst_n           = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_WEIGHT;
        req_ch.address    = '0;
        req_ch.data_value = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.data       = SHIFT_RESET;
        res_ch.ready      = 1'b0;
        m_shift           = SHIFT_RESET;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_first_inference();
        test_directed_cases();
        test_random_traffic();
        test_output_backpressure();

        wait_drained();
        $display("covered %0d request transfers (%0d stored), %0d inferences, %0d results",
                 total_transfers, items_sent, inference_count, results_seen);
        $display("requant_shift set %0d times incl. 0 and 31; random stalls and a long hold-off",
                 shift_writes);
        if (mismatches == 0) begin
            $display("tb_int8_mlp_classifier_top: clean");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("tb_int8_mlp_classifier_top: errors");
        end
        $finish;
    end

    // hang guard
    initial begin
        #LIMIT_NS;
        $display("timeout with %0d results still owed", logit_queue.size());
        $display("tb_int8_mlp_classifier_top: errors");
        $finish;
    end

endmodule
